/* src/tbvs_pkg.sv */
`default_nettype none

package tbvs_pkg;

	localparam int BONE_COUNT     = 2;
	localparam int MAT_DIM        = 4;
	localparam int POS_DIM        = 3;
	localparam int W_COL          = 3;
	localparam int ENTRY_PER_BONE = MAT_DIM * MAT_DIM;
	localparam int STORE_DEPTH    = BONE_COUNT * ENTRY_PER_BONE;
	localparam int IDX_W          = $clog2(STORE_DEPTH);
	localparam int DATA_W         = 32;
	localparam int WGT_W          = 17;
	localparam int FRAC           = 16;
	localparam int ACC_W          = 50;
	localparam int LANES          = BONE_COUNT * POS_DIM;
	localparam int INT_BITS       = 15;
	localparam int DIV_STEPS      = INT_BITS + FRAC;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_VERTEX = 1'b1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic               req_type;
		logic [IDX_W-1:0]   entry_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic [WGT_W-1:0]   weight_first;
		logic [WGT_W-1:0]   weight_second;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
	} res_t;

	typedef struct packed {
		logic [WGT_W-1:0] w0;
		logic [WGT_W-1:0] w1;
	} wgt_t;

endpackage

`default_nettype wire

/* src/tbvs_xform.sv */
`default_nettype none

module tbvs_xform (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  tbvs_pkg::req_t req,
	output logic acc_valid,
	input  logic acc_ready,
	output tbvs_pkg::acc_t acc [tbvs_pkg::BONE_COUNT][tbvs_pkg::MAT_DIM],
	output tbvs_pkg::wgt_t acc_wgt
);
	import tbvs_pkg::*;

	typedef logic signed [2*DATA_W-1:0] prod_t;

	logic [DATA_W-1:0] store_q [STORE_DEPTH];
	word_t pos [POS_DIM];
	prod_t prod_s1 [BONE_COUNT][POS_DIM][MAT_DIM];
	word_t m3_s1 [BONE_COUNT][MAT_DIM];
	prod_t sum_c [BONE_COUNT][MAT_DIM];
	acc_t  acc_s2 [BONE_COUNT][MAT_DIM];
	wgt_t  wgt_s1;
	wgt_t  wgt_s2;
	logic  v_s1;
	logic  v_s2;
	logic  en_s1;
	logic  en_s2;
	logic  take;

	assign en_s2     = !v_s2 || acc_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign req_ready = en_s1;
	assign take      = req_valid && en_s1;

	assign pos[0] = req.pos_x;
	assign pos[1] = req.pos_y;
	assign pos[2] = req.pos_z;

	// loads land at acceptance, so any later vertex sees them
	always_ff @(posedge clk) begin
		if (take && req.req_type == REQ_LOAD) begin
			store_q[req.entry_index] <= req.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= take && req.req_type == REQ_VERTEX;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int b = 0; b < BONE_COUNT; b++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					for (int r = 0; r < POS_DIM; r++) begin
						prod_s1[b][r][c] <= pos[r] *
							$signed(store_q[IDX_W'(b*ENTRY_PER_BONE + r*MAT_DIM + c)]);
					end
					m3_s1[b][c] <=
						$signed(store_q[IDX_W'(b*ENTRY_PER_BONE + W_COL*MAT_DIM + c)]);
				end
			end
			wgt_s1.w0 <= req.weight_first;
			wgt_s1.w1 <= req.weight_second;
		end
	end

	always_comb begin
		for (int b = 0; b < BONE_COUNT; b++) begin
			for (int c = 0; c < MAT_DIM; c++) begin
				sum_c[b][c] = (prod_s1[b][0][c] >>> FRAC) + (prod_s1[b][1][c] >>> FRAC)
					+ (prod_s1[b][2][c] >>> FRAC) + prod_t'(m3_s1[b][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int b = 0; b < BONE_COUNT; b++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					acc_s2[b][c] <= ACC_W'(sum_c[b][c]);
				end
			end
			wgt_s2 <= wgt_s1;
		end
	end

	assign acc       = acc_s2;
	assign acc_valid = v_s2;
	assign acc_wgt   = wgt_s2;

	a_vertex_enters: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.req_type == REQ_VERTEX |=> v_s1)
		else $error("vertex word lost at first stage");

	a_load_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		take && req.req_type == REQ_LOAD |=> !v_s1)
		else $error("load word took a pipeline slot");

endmodule

`default_nettype wire

/* src/tbvs_div.sv */
`default_nettype none

module tbvs_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tbvs_pkg::acc_t num [tbvs_pkg::LANES],
	input  tbvs_pkg::acc_t den [tbvs_pkg::LANES],
	input  tbvs_pkg::wgt_t in_wgt,
	output logic out_valid,
	input  logic out_ready,
	output tbvs_pkg::word_t quo [tbvs_pkg::LANES],
	output tbvs_pkg::wgt_t out_wgt
);
	import tbvs_pkg::*;

	// abs, setup, one stage per quotient bit, sign/saturate
	localparam int NS   = DIV_STEPS + 3;
	localparam int LAST = DIV_STEPS + 1;

	typedef logic [ACC_W-1:0] mag_t;
	typedef struct packed {
		mag_t                 r;
		mag_t                 ud;
		logic [DIV_STEPS-1:0] bits;
		logic [DIV_STEPS-1:0] q;
		logic                 neg;
		logic                 sat;
		logic                 zero;
	} lane_t;

	lane_t stg_s [LAST+1][LANES];
	lane_t nxt [LAST+1][LANES];
	wgt_t  wgt_s [NS];
	word_t quo_q [LANES];
	logic [NS-1:0] v_s;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= (en[NS-1:0] & {v_s[NS-2:0], in_valid}) | (~en[NS-1:0] & v_s);
		end
	end

	always_comb begin
		lane_t p;
		logic [ACC_W:0] t;
		logic ge;
		for (int l = 0; l < LANES; l++) begin
			nxt[0][l].r    = mag_t'(num[l][ACC_W-1] ? -num[l] : num[l]);
			nxt[0][l].ud   = mag_t'(den[l][ACC_W-1] ? -den[l] : den[l]);
			nxt[0][l].bits = '0;
			nxt[0][l].q    = '0;
			nxt[0][l].neg  = num[l][ACC_W-1] ^ den[l][ACC_W-1];
			nxt[0][l].sat  = 1'b0;
			nxt[0][l].zero = 1'b0;

			p = stg_s[0][l];
			nxt[1][l]      = p;
			nxt[1][l].zero = p.r == '0;
			nxt[1][l].sat  = (p.r != '0) &&
				({{INT_BITS{1'b0}}, p.r} >= {p.ud, {INT_BITS{1'b0}}});
			nxt[1][l].r    = p.r >> INT_BITS;
			nxt[1][l].bits = {p.r[INT_BITS-1:0], {FRAC{1'b0}}};

			for (int k = 2; k <= LAST; k++) begin
				p  = stg_s[k-1][l];
				t  = {p.r, p.bits[DIV_STEPS-1]};
				ge = t >= {1'b0, p.ud};
				nxt[k][l]      = p;
				nxt[k][l].r    = ge ? ACC_W'(t - {1'b0, p.ud}) : t[ACC_W-1:0];
				nxt[k][l].bits = p.bits << 1;
				nxt[k][l].q    = {p.q[DIV_STEPS-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			wgt_s[0] <= in_wgt;
		end
		for (int k = 1; k < NS; k++) begin
			if (en[k]) begin
				wgt_s[k] <= wgt_s[k-1];
			end
		end
		for (int k = 0; k <= LAST; k++) begin
			if (en[k]) begin
				stg_s[k] <= nxt[k];
			end
		end
		if (en[NS-1]) begin
			for (int l = 0; l < LANES; l++) begin
				if (stg_s[LAST][l].sat) begin
					quo_q[l] <= stg_s[LAST][l].neg ? SAT_MIN : SAT_MAX;
				end else if (stg_s[LAST][l].zero) begin
					quo_q[l] <= '0;
				end else if (stg_s[LAST][l].neg) begin
					quo_q[l] <= word_t'(-$signed({1'b0, stg_s[LAST][l].q}));
				end else begin
					quo_q[l] <= word_t'({1'b0, stg_s[LAST][l].q});
				end
			end
		end
	end

	assign quo       = quo_q;
	assign out_wgt   = wgt_s[NS-1];
	assign out_valid = v_s[NS-1];

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] && stg_s[1][0].ud == '0 |-> stg_s[1][0].sat || stg_s[1][0].zero)
		else $error("zero divisor not flagged");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST] && !stg_s[LAST][0].sat && !stg_s[LAST][0].zero
			|-> stg_s[LAST][0].r < stg_s[LAST][0].ud)
		else $error("partial remainder out of range");

endmodule

`default_nettype wire

/* src/tbvs_blend.sv */
`default_nettype none

module tbvs_blend (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tbvs_pkg::word_t quo [tbvs_pkg::LANES],
	input  tbvs_pkg::wgt_t in_wgt,
	output logic res_valid,
	input  logic res_ready,
	output tbvs_pkg::res_t res
);
	import tbvs_pkg::*;

	localparam int PROD_W = DATA_W + WGT_W + 1;

	typedef logic signed [PROD_W-1:0] wprod_t;
	typedef logic signed [PROD_W:0] wsum_t;

	wprod_t pa_s1 [POS_DIM];
	wprod_t pb_s1 [POS_DIM];
	word_t  blend_c [POS_DIM];
	res_t   res_s2;
	logic   v_s1;
	logic   v_s2;
	logic   en_s1;
	logic   en_s2;

	assign en_s2    = !v_s2 || res_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int j = 0; j < POS_DIM; j++) begin
				pa_s1[j] <= quo[j] * $signed({1'b0, in_wgt.w0});
				pb_s1[j] <= quo[j+POS_DIM] * $signed({1'b0, in_wgt.w1});
			end
		end
	end

	always_comb begin
		wsum_t s;
		for (int j = 0; j < POS_DIM; j++) begin
			s = (wsum_t'(pa_s1[j]) + wsum_t'(pb_s1[j])) >>> FRAC;
			if ((&s[PROD_W:DATA_W-1]) || !(|s[PROD_W:DATA_W-1])) begin
				blend_c[j] = s[DATA_W-1:0];
			end else begin
				blend_c[j] = s[PROD_W] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2.out_x <= blend_c[0];
			res_s2.out_y <= blend_c[1];
			res_s2.out_z <= blend_c[2];
		end
	end

	assign res       = res_s2;
	assign res_valid = v_s2;

endmodule

`default_nettype wire

/* src/two_bone_vertex_skinning_core.sv */
`default_nettype none

// Two-bone linear blend skinning, Q16.16. A load word (req_type 0) writes one
// entry of the 2 x 4x4 bone matrix store the cycle it is accepted and gives no
// result; a vertex word (req_type 1) gives one result word with the blended
// x, y, z. One word is taken per cycle, sustained, while the result side does
// not stall. A vertex passes through the matrix products and row sums, the six
// parallel perspective dividers (one quotient bit per stage, 31 bits), and the
// weighted blend and saturation. Stalls on the result side fill pipeline
// bubbles before input stops. Matrix entries must be loaded before a vertex
// uses them.
module two_bone_vertex_skinning_core (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  tbvs_pkg::req_t req,
	output logic res_valid,
	input  logic res_ready,
	output tbvs_pkg::res_t res
);
	import tbvs_pkg::*;

	acc_t  acc [BONE_COUNT][MAT_DIM];
	wgt_t  acc_wgt;
	logic  acc_valid;
	logic  acc_ready;
	acc_t  num [LANES];
	acc_t  den [LANES];
	word_t quo [LANES];
	wgt_t  quo_wgt;
	logic  quo_valid;
	logic  quo_ready;

	tbvs_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc),
		.acc_wgt   (acc_wgt)
	);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num[l] = acc[l / POS_DIM][l % POS_DIM];
			den[l] = acc[l / POS_DIM][W_COL];
		end
	end

	tbvs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc_valid),
		.in_ready  (acc_ready),
		.num       (num),
		.den       (den),
		.in_wgt    (acc_wgt),
		.out_valid (quo_valid),
		.out_ready (quo_ready),
		.quo       (quo),
		.out_wgt   (quo_wgt)
	);

	tbvs_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quo_valid),
		.in_ready  (quo_ready),
		.quo       (quo),
		.in_wgt    (quo_wgt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

/* bench/two_bone_vertex_skinning_core_checker.sv */
`timescale 1ns / 1ps

module two_bone_vertex_skinning_core_checker
	import tbvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   failures,
	output int   pending,
	output int   vertices_seen,
	output int   loads_seen
);

	logic [DATA_W-1:0] matrix_copy [STORE_DEPTH];
	res_t skinned_queue [$];

	function automatic longint floor16(longint v);
		return v >>> FRAC;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint persp_div(longint num, longint den);
		longint un, ud, q, r;
		logic neg;
		if (den == 0) begin
			if (num > 0)
				return 64'sd2147483647;
			if (num < 0)
				return -64'sd2147483648;
			return 0;
		end
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = un / ud;
		r = un % ud;
		if (q >= 32768)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		for (int i = 0; i < FRAC; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 1;
			end
		end
		return clamp32(neg ? -q : q);
	endfunction

	function automatic longint mat_at(int bone, int row, int col);
		return longint'($signed(matrix_copy[bone * ENTRY_PER_BONE + row * MAT_DIM + col]));
	endfunction

	function automatic res_t skin_vertex(req_t w);
		longint p [POS_DIM];
		longint pt [BONE_COUNT][POS_DIM];
		longint sum [MAT_DIM];
		longint blended;
		res_t o;
		p[0] = longint'(w.pos_x);
		p[1] = longint'(w.pos_y);
		p[2] = longint'(w.pos_z);
		for (int b = 0; b < BONE_COUNT; b++) begin
			for (int c = 0; c < MAT_DIM; c++) begin
				sum[c] = mat_at(b, 3, c);
				for (int r = 0; r < POS_DIM; r++)
					sum[c] += floor16(p[r] * mat_at(b, r, c));
			end
			for (int c = 0; c < POS_DIM; c++)
				pt[b][c] = persp_div(sum[c], sum[W_COL]);
		end
		for (int c = 0; c < POS_DIM; c++) begin
			blended = clamp32(floor16(pt[0][c] * longint'({1'b0, w.weight_first})
				+ pt[1][c] * longint'({1'b0, w.weight_second})));
			case (c)
				0: o.out_x = blended[31:0];
				1: o.out_y = blended[31:0];
				default: o.out_z = blended[31:0];
			endcase
		end
		return o;
	endfunction

	assign pending = skinned_queue.size();

	initial begin
		failures = 0;
		vertices_seen = 0;
		loads_seen = 0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (skinned_queue.size() == 0) begin
					failures++;
					$display("%0t: result word with none expected, actual %h", $time, res);
				end else begin
					want = skinned_queue.pop_front();
					if (want.out_x !== res.out_x || want.out_y !== res.out_y
						|| want.out_z !== res.out_z) begin
						failures++;
						$display("%0t: expected x=%h y=%h z=%h actual x=%h y=%h z=%h", $time,
							want.out_x, want.out_y, want.out_z, res.out_x, res.out_y, res.out_z);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.req_type == REQ_LOAD) begin
					matrix_copy[req.entry_index] = req.entry_value;
					loads_seen++;
				end else begin
					skinned_queue.push_back(skin_vertex(req));
					vertices_seen++;
				end
			end
		end
	end

endmodule

/* bench/two_bone_vertex_skinning_core_test.sv */
`timescale 1ns / 1ps

module two_bone_vertex_skinning_core_test;
	import tbvs_pkg::*;

	localparam int REQ_W = $bits(req_t);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;
	int failures, pending, vertices_seen, loads_seen;
	logic quiet;
	logic hold_long;

	two_bone_vertex_skinning_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	two_bone_vertex_skinning_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.failures(failures), .pending(pending),
		.vertices_seen(vertices_seen), .loads_seen(loads_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("two_bone_vertex_skinning_core: mismatch");
		$finish;
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h00000000;
			3: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
			4: return $urandom;
			default: return $urandom_range(0, 32'h7ffff) - 32'h3ffff;
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 17'h1ffff;
			1: return '0;
			2: return 17'h10000;
			default: return WGT_W'($urandom_range(0, 17'h10000));
		endcase
	endfunction

	task automatic send(input req_t w);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_entry(input int idx, input logic [31:0] v);
		req_t w;
		w = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.req_type = REQ_LOAD;
		w.entry_index = IDX_W'(idx);
		w.entry_value = v;
		send(w);
	endtask

	task automatic vertex(input logic [31:0] x, y, z, input logic [WGT_W-1:0] a, b);
		req_t w;
		w = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.req_type = REQ_VERTEX;
		w.pos_x = x;
		w.pos_y = y;
		w.pos_z = z;
		w.weight_first = a;
		w.weight_second = b;
		send(w);
	endtask

	task automatic load_identity_scaled(input int bone, input logic [31:0] s);
		for (int i = 0; i < ENTRY_PER_BONE; i++)
			load_entry(bone * ENTRY_PER_BONE + i,
				(i % 5 == 0) ? ((i == 15) ? 32'h10000 : s) : 32'h0);
	endtask

	initial begin
		int n;
		quiet = 1'b0;
		hold_long = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_identity_scaled(0, 32'h10000);
		load_identity_scaled(1, 32'h20000);
		vertex(32'h7fffffff, 32'h80000000, 32'h0, 17'h10000, 17'h0);
		vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 17'h0, 17'h10000);
		vertex(32'h00010000, 32'h00020000, 32'hfffd0000, 17'h1ffff, 17'h1ffff);
		vertex(32'h00018000, 32'h0, 32'h7fff0000, 17'h8000, 17'h8000);
		load_entry(15, 32'h0);
		vertex(32'h00010000, 32'hffff0000, 32'h0, 17'h10000, 17'h10000);
		vertex(32'h0, 32'h0, 32'h0, 17'h10000, 17'h0);
		load_entry(31, 32'hffff0000);
		vertex(32'h00030000, 32'h0, 32'h0, 17'h1ffff, 17'h10000);

		hold_long = 1'b1;
		for (int i = 0; i < 60; i++)
			vertex(rand_word(), rand_word(), rand_word(), rand_weight(), rand_weight());
		hold_long = 1'b0;

		n = 0;
		while (n < 550) begin
			if ($urandom_range(0, 9) == 0) begin
				load_entry($urandom_range(0, STORE_DEPTH - 1), rand_word());
			end else if ($urandom_range(0, 19) == 0) begin
				load_entry($urandom_range(0, 1) * ENTRY_PER_BONE + 15, 32'h0);
			end else begin
				vertex(rand_word(), rand_word(), rand_word(), rand_weight(), rand_weight());
			end
			n++;
			if (n == 450)
				quiet = 1'b1;
		end
		req_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("Covered %0d matrix loads and %0d vertices, with zero w, extreme", loads_seen,
			vertices_seen);
		$display("positions, weights above one and output stalls long enough to fill the pipe.");
		if (failures == 0)
			$display("two_bone_vertex_skinning_core: match");
		else
			$display("two_bone_vertex_skinning_core: mismatch");
		$finish;
	end

	initial begin
		int gap;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(posedge hold_long);
		@(negedge clk);
		repeat (200) @(negedge clk);
		while (1) begin
			res_ready <= 1'b1;
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 16);
				res_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

endmodule

/* files.f */
src/tbvs_pkg.sv
src/tbvs_xform.sv
src/tbvs_div.sv
src/tbvs_blend.sv
src/two_bone_vertex_skinning_core.sv
bench/two_bone_vertex_skinning_core_checker.sv
bench/two_bone_vertex_skinning_core_test.sv
